FILE: sv/bls_pkg.sv
package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int ERR_W      = COORD_BITS + 2;
    localparam int CMP_W      = ERR_W + 2;
    localparam int WIDTH_BITS = 11;
    localparam int HEIGHT_BITS = 10;
    localparam int ADDR_W     = 20;
    localparam int COLOR_W    = 8;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(320);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(200);

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [0:0]
    {
        REG_ROW_PITCH = 1'b0,
        REG_ROW_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COLOR_W-1:0]           color;
        logic                         last;
        logic                         no_line;
    } pix_t;

endpackage

FILE: sv/bresenham_line_pixel_stepper_top.sv
// Bresenham line stepper: a start transaction (cmd 0) loads both endpoints and the pen color and
// returns the first pixel; each step transaction (cmd 1) returns the next pixel of the line, with
// last set on the endpoint. A new transaction is taken every clock while item_stall is low; each
// result is registered by the line state update and then by the output register after the address
// multiply-add y * width + x. Pixels outside the configured screen come out with visible low and
// address zero, and a step with no line in progress returns the held position with last set.
// Write the row width (index 0) and the row count (index 1) only while no transaction is in
// flight.
module bresenham_line_pixel_stepper_top
    import bls_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [COLOR_W-1:0]           pen_color,
    output logic                         pixel_valid,
    input  logic                         pixel_stall,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [ADDR_W-1:0]            pixel_address,
    output logic [COLOR_W-1:0]           pixel_color,
    output logic                         visible,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [WIDTH_BITS-1:0]        cfg_data
);

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_en;
    logic                   s1_en;
    logic                   take;
    pix_t                   pix;

    always_comb
    begin
        out_en = !out_valid_reg || !pixel_stall;
        s1_en = !s1_valid_reg || out_en;
        take = item_valid && s1_en;
        s1_valid_next = s1_en ? item_valid : s1_valid_reg;
        out_valid_next = out_en ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_PITCH: width_reg <= cfg_data;
                REG_ROW_COUNT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default:       width_reg <= width_reg;
            endcase
        end
    end

    bls_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .cmd       (cmd),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .pen_color (pen_color),
        .pix       (pix)
    );

    bls_out u_out
    (
        .clk           (clk),
        .load          (out_en && s1_valid_reg),
        .pix           (pix),
        .row_pitch     (width_reg),
        .row_count     (height_reg),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .visible       (visible),
        .last          (last)
    );

    assign item_stall = !s1_en;
    assign pixel_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: sv/bls_core.sv
module bls_core
    import bls_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic [COLOR_W-1:0]           pen_color,
    output pix_t                         pix
);

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic [DELTA_W-1:0]           abs_dx_reg, abs_dx_next;
    logic [DELTA_W-1:0]           abs_dy_reg, abs_dy_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic [COLOR_W-1:0]           color_reg, color_next;
    logic                         active_reg, active_next;
    pix_t                         pix_reg, pix_next;

    logic signed [DELTA_W-1:0] sdx;
    logic signed [DELTA_W-1:0] sdy;
    logic signed [ERR_W:0]     e2;
    logic signed [CMP_W-1:0]   e2_w;
    logic signed [CMP_W-1:0]   dx_w;
    logic signed [CMP_W-1:0]   dy_w;
    logic signed [CMP_W-1:0]   err_acc;
    logic                      move_x;
    logic                      move_y;
    logic                      done;

    always_comb
    begin
        sdx = DELTA_W'(end_x) - DELTA_W'(start_x);
        sdy = DELTA_W'(end_y) - DELTA_W'(start_y);
        e2 = {err_reg, 1'b0};
        e2_w = CMP_W'(e2);
        dx_w = $signed(CMP_W'(abs_dx_reg));
        dy_w = $signed(CMP_W'(abs_dy_reg));
        move_x = e2_w > -dy_w;
        move_y = e2_w < dx_w;
        err_acc = CMP_W'(err_reg) - (move_x ? dy_w : CMP_W'(0)) + (move_y ? dx_w : CMP_W'(0));

        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        err_next = err_reg;
        color_next = color_reg;
        active_next = active_reg;
        done = 1'b1;

        if (cmd == CMD_START)
        begin
            cur_x_next = start_x;
            cur_y_next = start_y;
            goal_x_next = end_x;
            goal_y_next = end_y;
            abs_dx_next = sdx[DELTA_W-1] ? DELTA_W'(-sdx) : DELTA_W'(sdx);
            abs_dy_next = sdy[DELTA_W-1] ? DELTA_W'(-sdy) : DELTA_W'(sdy);
            step_x_neg_next = sdx[DELTA_W-1] || (sdx == '0);
            step_y_neg_next = sdy[DELTA_W-1] || (sdy == '0);
            err_next = $signed(ERR_W'(abs_dx_next)) - $signed(ERR_W'(abs_dy_next));
            color_next = pen_color;
            done = (start_x == end_x) && (start_y == end_y);
            active_next = !done;
        end
        else if (active_reg)
        begin
            if (move_x)
            begin
                cur_x_next = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                            : cur_x_reg + COORD_BITS'(1);
            end
            if (move_y)
            begin
                cur_y_next = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                            : cur_y_reg + COORD_BITS'(1);
            end
            err_next = err_acc[ERR_W-1:0];
            done = (cur_x_next == goal_x_reg) && (cur_y_next == goal_y_reg);
            active_next = !done;
        end

        pix_next.x = cur_x_next;
        pix_next.y = cur_y_next;
        pix_next.color = color_next;
        pix_next.last = done;
        pix_next.no_line = (cmd == CMD_STEP) && !active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            abs_dx_reg <= '0;
            abs_dy_reg <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            err_reg <= '0;
            color_reg <= '0;
            active_reg <= 1'b0;
        end
        else if (take)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            abs_dx_reg <= abs_dx_next;
            abs_dy_reg <= abs_dy_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            err_reg <= err_next;
            color_reg <= color_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

FILE: sv/bls_out.sv
module bls_out
    import bls_pkg::*;
(
    input  logic                         clk,
    input  logic                         load,
    input  pix_t                         pix,
    input  logic [WIDTH_BITS-1:0]        row_pitch,
    input  logic [HEIGHT_BITS-1:0]       row_count,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [ADDR_W-1:0]            pixel_address,
    output logic [COLOR_W-1:0]           pixel_color,
    output logic                         visible,
    output logic                         last
);

    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic [ADDR_W-1:0]            addr_reg, addr_next;
    logic [COLOR_W-1:0]           color_reg;
    logic                         vis_reg, vis_next;
    logic                         last_reg;

    logic [ADDR_W-1:0] xz;
    logic [ADDR_W-1:0] yz;
    logic [ADDR_W-1:0] wz;
    logic [ADDR_W-1:0] hz;

    always_comb
    begin
        xz = ADDR_W'($unsigned(pix.x));
        yz = ADDR_W'($unsigned(pix.y));
        wz = ADDR_W'(row_pitch);
        hz = ADDR_W'(row_count);
        vis_next = !pix.no_line && !pix.x[COORD_BITS-1] && !pix.y[COORD_BITS-1]
                   && (xz < wz) && (yz < hz);
        addr_next = vis_next ? ADDR_W'(yz * wz + xz) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= pix.x;
            y_reg <= pix.y;
            addr_reg <= addr_next;
            color_reg <= pix.color;
            vis_reg <= vis_next;
            last_reg <= pix.last;
        end
    end

    assign pixel_x = x_reg;
    assign pixel_y = y_reg;
    assign pixel_address = addr_reg;
    assign pixel_color = color_reg;
    assign visible = vis_reg;
    assign last = last_reg;

endmodule

FILE: sv/bls_checker.sv
module bls_checker
    import bls_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_stall,
    input logic                         pixel_valid,
    input logic                         pixel_stall,
    input logic signed [COORD_BITS-1:0] pixel_x,
    input logic signed [COORD_BITS-1:0] pixel_y,
    input logic [ADDR_W-1:0]            pixel_address,
    input logic                         visible
);

    // A stalled result transaction keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_address)
            && $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled pixel transaction changed");

    // A clipped pixel never carries an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !visible |-> pixel_address == '0)
    else $error("invisible pixel with nonzero address");

    // A visible pixel has nonnegative coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && visible |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
    else $error("visible pixel with negative coordinate");

    // With the result side free, the input side is never stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_valid |-> !item_stall)
    else $error("input stalled while output empty");

endmodule

bind bresenham_line_pixel_stepper_top bls_checker u_bls_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .item_stall    (item_stall),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .visible       (visible)
);
